@@ rtl/fifo_run_queue_scheduler_macros.svh @@
// Assertion macros for the run queue scheduler checker.
// Each expects clk and rst in scope; rst disables checking.
`ifndef FIFO_RUN_QUEUE_SCHEDULER_MACROS_SVH
`define FIFO_RUN_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define FRQS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frqs check failed");

// implication checked on the following edge
`define FRQS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frqs check failed");

// delayed implication
`define FRQS_ASSERT_DLY2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("frqs check failed");

`endif

@@ rtl/frqs_pkg.sv @@
// Shared types and constants for the FIFO run queue scheduler.
// No dependencies.
package frqs_pkg;

  localparam int TID_W       = 6;
  localparam int MAX_THREADS = 64;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THREAD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PRESENT = 1'b1;

  typedef enum logic [2:0] {
    OP_PICK_NEXT = 3'd0,
    OP_PICK_LAST = 3'd1,
    OP_ENQUEUE   = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_YIELD     = 3'd4
  } frqs_op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_IDLE   = 2'd1,
    ST_QUEUED = 2'd2
  } frqs_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_LINK,
    S_TAIL
  } frqs_state_t;

  typedef struct packed {
    frqs_op_t          op;
    logic [TID_W-1:0]  thread_id;
  } frqs_cmd_t;

  typedef struct packed {
    logic [TID_W-1:0]  picked_thread;
    logic              picked_valid;
    frqs_status_t      status;
  } frqs_result_t;

  // word of the backward-link memory: queued flag plus previous thread
  typedef struct packed {
    logic              queued;
    logic [TID_W-1:0]  prev;
  } frqs_pword_t;

endpackage

@@ rtl/frqs_ram.sv @@
// Single-port-write, single-port-read synchronous RAM, registered read.
// Depends on nothing.
module frqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/frqs_ctrl.sv @@
// Request sequencer: reads the thread's links, updates head/tail and
// writes back neighbor links one memory write per port per cycle. Uses frqs_pkg.
module frqs_ctrl
  import frqs_pkg::*;
#(
  parameter int MAX_THREADS = frqs_pkg::MAX_THREADS,
  localparam int IDX_W = $clog2(MAX_THREADS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  frqs_cmd_t           cmd,
  output logic                busy,
  output logic                done,
  output frqs_result_t        result,
  input  logic [TID_W-1:0]    cfg_idle_thread,
  input  logic                cfg_idle_present,
  output logic [IDX_W-1:0]    rd_addr,
  input  logic [TID_W-1:0]    next_rdata,
  input  frqs_pword_t         prev_rdata,
  output logic                next_we,
  output logic [IDX_W-1:0]    next_waddr,
  output logic [TID_W-1:0]    next_wdata,
  output logic                prev_we,
  output logic [IDX_W-1:0]    prev_waddr,
  output frqs_pword_t         prev_wdata
);

  frqs_state_t state, state_next;

  logic [IDX_W-1:0] clr_addr;
  frqs_op_t         op_r;
  logic [TID_W-1:0] tid_r;
  logic [TID_W-1:0] head, head_next;
  logic [TID_W-1:0] tail, tail_next;
  logic             empty, empty_next;
  logic [TID_W-1:0] w_tail, w_prev;
  logic             w_nonempty, w_append;

  logic             is_mod, idle_hit, in_range, act;
  logic             do_unlink, do_append, sole;
  logic [TID_W-1:0] head_u, tail_u, prev_new;
  logic             empty_u;
  frqs_result_t     result_next;
  logic [IDX_W-1:0] t_idx;

  assign busy    = (state != S_IDLE);
  assign rd_addr = IDX_W'(cmd.thread_id);
  assign t_idx   = IDX_W'(tid_r);

  // evaluation of the request against the links read for it
  always_comb begin
    is_mod   = (op_r == OP_ENQUEUE) || (op_r == OP_REMOVE) || (op_r == OP_YIELD);
    idle_hit = cfg_idle_present && (tid_r == cfg_idle_thread);
    in_range = 32'(tid_r) < 32'(MAX_THREADS);
    act      = is_mod && !idle_hit && in_range;
    do_unlink = act && prev_rdata.queued && ((op_r == OP_REMOVE) || (op_r == OP_YIELD));
    do_append = act && (((op_r == OP_ENQUEUE) && !prev_rdata.queued) ||
                        (op_r == OP_YIELD));
    sole = (head == tid_r) && (tail == tid_r);

    head_u  = head;
    tail_u  = tail;
    empty_u = empty;
    if (do_unlink) begin
      if (sole) begin
        empty_u = 1'b1;
      end else begin
        if (head == tid_r) begin
          head_u = next_rdata;
        end
        if (tail == tid_r) begin
          tail_u = prev_rdata.prev;
        end
      end
    end

    head_next  = head_u;
    tail_next  = tail_u;
    empty_next = empty_u;
    prev_new   = tail_u;
    if (do_append) begin
      if (empty_u) begin
        head_next = tid_r;
        prev_new  = tid_r;
      end
      tail_next  = tid_r;
      empty_next = 1'b0;
    end

    result_next = '{picked_thread: '0, picked_valid: 1'b0, status: ST_DONE};
    unique case (op_r)
      OP_PICK_NEXT: begin
        if (!empty) begin
          result_next.picked_thread = head;
          result_next.picked_valid  = 1'b1;
        end else if (cfg_idle_present) begin
          result_next.picked_thread = cfg_idle_thread;
          result_next.picked_valid  = 1'b1;
        end
      end
      OP_PICK_LAST: begin
        if (!empty) begin
          result_next.picked_thread = tail;
          result_next.picked_valid  = 1'b1;
        end
      end
      OP_ENQUEUE, OP_REMOVE, OP_YIELD: begin
        if (idle_hit) begin
          result_next.status = ST_IDLE;
        end else if (act && (op_r == OP_ENQUEUE) && prev_rdata.queued) begin
          result_next.status = ST_QUEUED;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == IDX_W'(MAX_THREADS - 1)) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_EVAL;
      S_EVAL:  if (do_append || do_unlink) state_next = S_LINK;
               else state_next = S_IDLE;
      S_LINK:  state_next = w_append ? S_TAIL : S_IDLE;
      S_TAIL:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory write-back per state
  always_comb begin
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        next_we    = 1'b1;
        next_waddr = clr_addr;
        prev_we    = 1'b1;
        prev_waddr = clr_addr;
      end
      S_EVAL: begin
        // bridge the neighbors around the thread being taken out
        if (do_unlink && !sole && (head != tid_r)) begin
          next_we    = 1'b1;
          next_waddr = IDX_W'(prev_rdata.prev);
          next_wdata = next_rdata;
        end
        if (do_unlink && !sole && (tail != tid_r)) begin
          prev_we    = 1'b1;
          prev_waddr = IDX_W'(next_rdata);
          prev_wdata = '{queued: 1'b1, prev: prev_rdata.prev};
        end
      end
      S_LINK: begin
        prev_we    = 1'b1;
        prev_waddr = t_idx;
        prev_wdata = '{queued: w_append, prev: w_prev};
        if (w_append && w_nonempty) begin
          next_we    = 1'b1;
          next_waddr = IDX_W'(w_tail);
          next_wdata = tid_r;
        end
      end
      S_TAIL: begin
        // new tail points at itself
        next_we    = 1'b1;
        next_waddr = t_idx;
        next_wdata = tid_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EVAL);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_EVAL) begin
        head  <= head_next;
        tail  <= tail_next;
        empty <= empty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      op_r  <= cmd.op;
      tid_r <= cmd.thread_id;
    end
    if (state == S_EVAL) begin
      result     <= result_next;
      w_tail     <= tail_u;
      w_prev     <= prev_new;
      w_nonempty <= !empty_u;
      w_append   <= do_append;
    end
  end

endmodule

@@ rtl/fifo_run_queue_scheduler.sv @@
// FIFO run queue scheduler: done is registered from S_EVAL, the state a taken request
// enters first. Picks and requests that change no link use S_EVAL only, a remove that
// unlinks adds S_LINK, an enqueue/yield append adds S_LINK and S_TAIL (busy high in
// each), set by the one write port per link memory (up to three writes per append).
// Result is held from done until the next evaluation; the receiver cannot stall it.
// After reset a clearing pass writes every link memory entry with busy high.
module fifo_run_queue_scheduler
  import frqs_pkg::*;
#(
  parameter int MAX_THREADS = frqs_pkg::MAX_THREADS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  frqs_cmd_t            cmd,
  output logic                 busy,
  output logic                 done,
  output frqs_result_t         result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TID_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(MAX_THREADS);

  logic [TID_W-1:0] idle_thread;
  logic             idle_present;

  logic [IDX_W-1:0] rd_addr;
  logic [TID_W-1:0] next_rdata;
  frqs_pword_t      prev_rdata;
  logic             next_we, prev_we;
  logic [IDX_W-1:0] next_waddr, prev_waddr;
  logic [TID_W-1:0] next_wdata;
  frqs_pword_t      prev_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_thread  <= '0;
      idle_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDLE_THREAD:  idle_thread  <= cfg_data;
        CFG_IDLE_PRESENT: idle_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  frqs_ctrl #(.MAX_THREADS(MAX_THREADS)) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .cmd              (cmd),
    .busy             (busy),
    .done             (done),
    .result           (result),
    .cfg_idle_thread  (idle_thread),
    .cfg_idle_present (idle_present),
    .rd_addr          (rd_addr),
    .next_rdata       (next_rdata),
    .prev_rdata       (prev_rdata),
    .next_we          (next_we),
    .next_waddr       (next_waddr),
    .next_wdata       (next_wdata),
    .prev_we          (prev_we),
    .prev_waddr       (prev_waddr),
    .prev_wdata       (prev_wdata)
  );

  // forward links
  frqs_ram #(.WIDTH(TID_W), .DEPTH(MAX_THREADS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (next_rdata)
  );

  // backward links with queued flag
  frqs_ram #(.WIDTH($bits(frqs_pword_t)), .DEPTH(MAX_THREADS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (prev_rdata)
  );

endmodule

@@ rtl/frqs_checker.sv @@
// Port-level checks for the run queue scheduler, bound to the top level.
// Uses frqs_pkg and fifo_run_queue_scheduler_macros.svh.
`include "fifo_run_queue_scheduler_macros.svh"

module frqs_checker
  import frqs_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input logic         done,
  input frqs_result_t result
);

  `FRQS_ASSERT_NXT(a_take_busy, start && !busy, busy)
  `FRQS_ASSERT_DLY2(a_take_done, start && !busy, done)
  `FRQS_ASSERT_IMP(a_no_pick_zero, done && !result.picked_valid, result.picked_thread == '0)
  `FRQS_ASSERT_IMP(a_flag_no_pick, done && (result.status != ST_DONE), !result.picked_valid)

endmodule

bind fifo_run_queue_scheduler frqs_checker u_frqs_checker (.*);
